[hw/rtl/rde_pkg.sv]
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and constants of the Richardson derivative estimator: word
// widths, the operand pair of the shared multiplier and the reciprocal table
// used to divide by 4^j - 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rde_pkg;

    localparam int DATA_W     = 32;
    localparam int STEP_W     = 31;
    localparam int LEVEL_W    = 4;
    localparam int LCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 33;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_op_t;

    // floor(2^33 / (4^j - 1)), j = 1 .. 15
    function automatic logic [MUL_B_W-1:0] recip_of(input logic [LEVEL_W-1:0] j);
        logic [MUL_B_W-1:0] r;
        unique case (j)
            4'd1:    r = 32'd2863311530;
            4'd2:    r = 32'd572662306;
            4'd3:    r = 32'd136348168;
            4'd4:    r = 32'd33686018;
            4'd5:    r = 32'd8396808;
            4'd6:    r = 32'd2097664;
            4'd7:    r = 32'd524320;
            4'd8:    r = 32'd131074;
            4'd9:    r = 32'd32768;
            4'd10:   r = 32'd8192;
            4'd11:   r = 32'd2048;
            4'd12:   r = 32'd512;
            4'd13:   r = 32'd128;
            4'd14:   r = 32'd32;
            4'd15:   r = 32'd8;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/rde_row_ram.sv]
// ----------------------------------------------------------------------------
// rde_row_ram
// Single-port-write, single-port-read synchronous memory holding the last
// Richardson row; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rde_row_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [rde_pkg::DATA_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [rde_pkg::DATA_W-1:0] rd_data_reg
);

    logic signed [rde_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/rde_mul.sv]
// ----------------------------------------------------------------------------
// rde_mul
// Shared unsigned 33 x 32 multiplier with a registered product; serves the
// central difference scaling and the reciprocal divide of each row entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rde_mul (
    input  logic                              aclk,
    input  rde_pkg::mul_op_t                  op,
    output logic [rde_pkg::MUL_P_W-1:0]       prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= rde_pkg::MUL_P_W'(op.a) * rde_pkg::MUL_P_W'(op.b);
    end

endmodule

[hw/rtl/richardson_derivative_estimator_unit.sv]
// ----------------------------------------------------------------------------
// richardson_derivative_estimator_unit
// Level i of a sequence runs the scaling step and then i row entries
// before its result is loaded into the output register; each row
// entry takes three steps: memory read, one pass through the shared
// multiplier, and the quotient correction.
// One word is worked on at a time; a new word is taken while the last result
// waits in the output register, a result still waiting there stalls the next.
// Reset restores the register defaults and level 0; the row memory is not
// cleared, every entry is written before read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module richardson_derivative_estimator_unit #(
    parameter int MAX_LEVELS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [rde_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rde_pkg::DATA_W-1:0]           cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [rde_pkg::DATA_W-1:0]    s_sample_plus,
    input  logic signed [rde_pkg::DATA_W-1:0]    s_sample_minus,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rde_pkg::DATA_W-1:0]    m_estimate,
    output logic                                 m_is_final,
    output logic signed [rde_pkg::DATA_W-1:0]    m_next_plus_point,
    output logic signed [rde_pkg::DATA_W-1:0]    m_next_minus_point,
    output logic                                 m_saturated
);

    localparam int ADDR_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int DW     = rde_pkg::DATA_W;
    localparam int SW     = rde_pkg::STEP_W;
    localparam int LW     = rde_pkg::LEVEL_W;
    localparam int CW     = rde_pkg::LCOUNT_W;

    localparam logic [CW-1:0] LV_MAX = CW'(MAX_LEVELS);
    localparam logic [5:0]    FB     = 6'(FRAC_BITS);

    localparam logic [rde_pkg::CFG_IDX_W-1:0] CFG_CENTER_POINT = 4'd0;
    localparam logic [rde_pkg::CFG_IDX_W-1:0] CFG_STEP_SIZE    = 4'd1;
    localparam logic [rde_pkg::CFG_IDX_W-1:0] CFG_INV_TWICE    = 4'd2;
    localparam logic [rde_pkg::CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_LOAD,
        ST_RMUL,
        ST_CORR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             sat;
        logic signed [DW-1:0] value;
    } sat_val_t;

    function automatic sat_val_t from_mag(input logic neg, input logic [63:0] mag);
        sat_val_t   r;
        logic [63:0] lim;
        logic [63:0] m;
        lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        m   = mag;
        r.sat = 1'b0;
        if (mag > lim) begin
            m     = lim;
            r.sat = 1'b1;
        end
        r.value = neg ? (~m[DW-1:0] + 32'd1) : m[DW-1:0];
        return r;
    endfunction

    function automatic sat_val_t clamp34(input logic signed [33:0] v);
        sat_val_t r;
        r.sat = 1'b0;
        r.value = v[DW-1:0];
        if (v > 34'sd2147483647) begin
            r.sat   = 1'b1;
            r.value = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r.sat   = 1'b1;
            r.value = 32'sh8000_0000;
        end
        return r;
    endfunction

    state_t state_reg;

    logic signed [DW-1:0] center_reg;
    logic [SW-1:0]        step_reg;
    logic [SW-1:0]        inv_reg;
    logic [CW-1:0]        lcount_reg;
    logic [LW-1:0]        level_reg;
    logic [SW-1:0]        cur_step_reg;

    logic                 diff_neg_reg;
    logic [32:0]          diff_mag_reg;
    logic [LW-1:0]        lvl_reg;
    logic [LW-1:0]        j_reg;
    logic signed [DW-1:0] cur_reg;
    logic                 sat_reg;
    logic [32:0]          x_reg;
    logic                 eneg_reg;

    logic                 m_valid_reg;
    logic signed [DW-1:0] est_reg;
    logic                 fin_reg;
    logic signed [DW-1:0] plus_reg;
    logic signed [DW-1:0] minus_reg;
    logic                 msat_reg;

    // memory and multiplier hookup
    logic                 row_wr_en;
    logic [ADDR_W-1:0]    row_wr_addr;
    logic                 row_rd_en;
    logic [ADDR_W-1:0]    row_rd_addr;
    logic signed [DW-1:0] row_rd_data;
    rde_pkg::mul_op_t     mul_op;
    logic [rde_pkg::MUL_P_W-1:0] mul_p;

    // control
    logic [CW-1:0]        lv_eff;
    logic [LW-1:0]        lvl_start;
    logic                 accept_in;
    logic                 can_out;
    logic                 fin_now;
    logic [SW-1:0]        step_next;

    // input difference
    logic signed [32:0]   diff_w;
    logic [32:0]          diff_abs;

    // scaling of the central difference
    logic [63:0]          prod64;
    logic [5:0]           lvl6;
    logic [5:0]           rsh;
    logic [3:0]           lsh;
    logic [63:0]          rnd;
    logic [63:0]          lim_l;
    logic [63:0]          scaled;
    sat_val_t             scale_sv;

    // extrapolation step
    logic signed [32:0]   e_w;
    logic [32:0]          e_abs;
    logic [4:0]           two_j;
    logic [32:0]          half_d;
    logic [32:0]          x_next;
    logic [31:0]          q_est;
    logic [34:0]          qd;
    logic [34:0]          rem;
    logic [34:0]          d_w;
    logic [32:0]          q_fix;
    logic signed [33:0]   sum_w;
    sat_val_t             corr_sv;

    // abscissas
    logic signed [33:0]   plus_w;
    logic signed [33:0]   minus_w;
    sat_val_t             plus_sv;
    sat_val_t             minus_sv;

    rde_row_ram #(
        .DEPTH  (MAX_LEVELS),
        .ADDR_W (ADDR_W)
    ) u_row_ram (
        .aclk        (aclk),
        .wr_en       (row_wr_en),
        .wr_addr     (row_wr_addr),
        .wr_data     (cur_reg),
        .rd_en       (row_rd_en),
        .rd_addr     (row_rd_addr),
        .rd_data_reg (row_rd_data)
    );

    rde_mul u_mul (
        .aclk     (aclk),
        .op       (mul_op),
        .prod_reg (mul_p)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign can_out   = !m_valid_reg || m_ready;

    assign m_valid            = m_valid_reg;
    assign m_estimate         = est_reg;
    assign m_is_final         = fin_reg;
    assign m_next_plus_point  = plus_reg;
    assign m_next_minus_point = minus_reg;
    assign m_saturated        = msat_reg;

    always_comb begin
        if (lcount_reg == '0) begin
            lv_eff = CW'(1);
        end else if (lcount_reg > LV_MAX) begin
            lv_eff = LV_MAX;
        end else begin
            lv_eff = lcount_reg;
        end
        lvl_start = ({1'b0, level_reg} >= lv_eff) ? '0 : level_reg;
        fin_now   = ({1'b0, lvl_reg} + CW'(1)) >= lv_eff;
        step_next = fin_now ? step_reg : (cur_step_reg >> 1);
    end

    // input difference and its magnitude
    always_comb begin
        diff_w   = {s_sample_plus[DW-1], s_sample_plus} - {s_sample_minus[DW-1], s_sample_minus};
        diff_abs = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
    end

    // multiplier operands
    always_comb begin
        if (state_reg == ST_RMUL) begin
            mul_op.a = x_reg;
            mul_op.b = rde_pkg::recip_of(j_reg);
        end else begin
            mul_op.a = diff_mag_reg;
            mul_op.b = {1'b0, inv_reg};
        end
    end

    // memory ports
    always_comb begin
        row_wr_en   = (state_reg == ST_LOAD) || (state_reg == ST_FIN);
        row_wr_addr = (state_reg == ST_LOAD) ? ADDR_W'(j_reg - 4'd1) : ADDR_W'(lvl_reg);
        row_rd_en   = ((state_reg == ST_SCALE) && (lvl_reg != '0))
                   || ((state_reg == ST_CORR) && (j_reg != lvl_reg));
        row_rd_addr = (state_reg == ST_SCALE) ? '0 : ADDR_W'(j_reg);
    end

    // central difference times 1/(2h), scaled by 2^(i - FRAC_BITS)
    always_comb begin
        prod64 = mul_p[63:0];
        lvl6   = {2'b00, lvl_reg};
        rsh    = '0;
        lsh    = '0;
        rnd    = '0;
        lim_l  = '0;
        if (lvl6 <= FB) begin
            rsh    = FB - lvl6;
            rnd    = (rsh == '0) ? 64'd0 : (64'd1 << (rsh - 6'd1));
            scaled = (prod64 + rnd) >> rsh;
        end else begin
            lsh    = 4'(lvl6 - FB);
            lim_l  = 64'h0000_0000_8000_0000 >> lsh;
            scaled = (prod64 > lim_l) ? 64'h0000_0001_0000_0000 : (prod64 << lsh);
        end
        scale_sv = from_mag(diff_neg_reg, scaled);
    end

    // row entry j: R = cur + round((cur - old) / (4^j - 1))
    always_comb begin
        e_w    = {cur_reg[DW-1], cur_reg} - {row_rd_data[DW-1], row_rd_data};
        e_abs  = e_w[32] ? 33'(-e_w) : 33'(e_w);
        two_j  = {j_reg, 1'b0};
        half_d = (33'd1 << (two_j - 5'd1)) - 33'd1;
        x_next = e_abs + half_d;

        q_est  = mul_p[rde_pkg::MUL_P_W-1:rde_pkg::RECIP_SHIFT];
        qd     = (35'(q_est) << two_j) - 35'(q_est);
        rem    = 35'(x_reg) - qd;
        d_w    = (35'd1 << two_j) - 35'd1;
        q_fix  = 33'(q_est) + ((rem >= d_w) ? 33'd1 : 33'd0);
        sum_w  = {{2{cur_reg[DW-1]}}, cur_reg}
               + (eneg_reg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix}));
        corr_sv = clamp34(sum_w);
    end

    // abscissas of the next sample
    always_comb begin
        plus_w   = {{2{center_reg[DW-1]}}, center_reg} + $signed({3'b000, step_next});
        minus_w  = {{2{center_reg[DW-1]}}, center_reg} - $signed({3'b000, step_next});
        plus_sv  = clamp34(plus_w);
        minus_sv = clamp34(minus_w);
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            diff_neg_reg <= diff_w[32];
            diff_mag_reg <= diff_abs;
            lvl_reg      <= lvl_start;
        end
        unique case (state_reg)
            ST_SCALE: begin
                cur_reg <= scale_sv.value;
                sat_reg <= scale_sv.sat;
                j_reg   <= 4'd1;
            end
            ST_LOAD: begin
                x_reg    <= x_next;
                eneg_reg <= e_w[32];
            end
            ST_CORR: begin
                cur_reg <= corr_sv.value;
                sat_reg <= sat_reg | corr_sv.sat;
                j_reg   <= j_reg + 4'd1;
            end
            default: begin
            end
        endcase
    end

    // sequencer, configuration and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            center_reg   <= '0;
            step_reg     <= 31'd655;
            inv_reg      <= 31'd3276800;
            lcount_reg   <= 5'd5;
            level_reg    <= '0;
            cur_step_reg <= 31'd655;
            m_valid_reg  <= 1'b0;
            est_reg      <= '0;
            fin_reg      <= 1'b0;
            plus_reg     <= '0;
            minus_reg    <= '0;
            msat_reg     <= 1'b0;
        end else begin
            // a word loaded in the finish state replaces the one taken
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    state_reg <= (lvl_reg == '0) ? ST_FIN : ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg <= ST_RMUL;
                end
                ST_RMUL: begin
                    state_reg <= ST_CORR;
                end
                ST_CORR: begin
                    state_reg <= (j_reg == lvl_reg) ? ST_FIN : ST_LOAD;
                end
                ST_FIN: begin
                    if (can_out) begin
                        state_reg    <= ST_IDLE;
                        m_valid_reg  <= 1'b1;
                        est_reg      <= cur_reg;
                        fin_reg      <= fin_now;
                        plus_reg     <= plus_sv.value;
                        minus_reg    <= minus_sv.value;
                        msat_reg     <= sat_reg | plus_sv.sat | minus_sv.sat;
                        level_reg    <= fin_now ? '0 : (lvl_reg + 4'd1);
                        cur_step_reg <= step_next;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // any write restarts the sequence
            if (cfg_wr_en) begin
                level_reg    <= '0;
                cur_step_reg <= (cfg_index == CFG_STEP_SIZE) ? cfg_data[SW-1:0] : step_reg;
                unique case (cfg_index)
                    CFG_CENTER_POINT: center_reg <= cfg_data;
                    CFG_STEP_SIZE:    step_reg   <= cfg_data[SW-1:0];
                    CFG_INV_TWICE:    inv_reg    <= cfg_data[SW-1:0];
                    CFG_LEVEL_COUNT:  lcount_reg <= cfg_data[CW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[verif/rde_tb_pkg.sv]
// ----------------------------------------------------------------------------
// rde_tb_pkg
// Register map shared by the stimulus and the result checker of the
// Richardson derivative estimator testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rde_tb_pkg;

    localparam int CFG_REG_COUNT = 4;

    typedef enum logic [3:0] {
        REG_CENTER_POINT   = 4'd0,
        REG_STEP_SIZE      = 4'd1,
        REG_INV_TWICE_STEP = 4'd2,
        REG_LEVEL_COUNT    = 4'd3
    } cfg_reg_e;

endpackage

[verif/rde_result_checker.sv]
// ----------------------------------------------------------------------------
// rde_result_checker
// Watches the configuration port and both word channels of the estimator,
// keeps its own copy of the registers, the Richardson row and the level
// state, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rde_result_checker
    import rde_pkg::*;
    import rde_tb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [DATA_W-1:0]        s_sample_plus,
    input  logic [DATA_W-1:0]        s_sample_minus,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [DATA_W-1:0]        m_estimate,
    input  logic                     m_is_final,
    input  logic [DATA_W-1:0]        m_next_plus_point,
    input  logic [DATA_W-1:0]        m_next_minus_point,
    input  logic                     m_saturated,
    output int                       pending,
    output int                       error_count
);

    localparam int MAX_LEVELS = 16;
    localparam int FRAC_BITS  = 16;

    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic              is_final;
        logic [DATA_W-1:0] next_plus_point;
        logic [DATA_W-1:0] next_minus_point;
        logic              saturated;
    } deriv_word_t;

    deriv_word_t         expected_q[$];
    longint              row_mem[MAX_LEVELS];
    logic [LEVEL_W-1:0]  level_now;
    logic [DATA_W-1:0]   step_now;
    logic [DATA_W-1:0]   reg_center;
    logic [STEP_W-1:0]   reg_step;
    logic [STEP_W-1:0]   reg_inv;
    logic [LCOUNT_W-1:0] reg_levels;
    bit                  clamp_hit;

    function automatic void restart_sequence();
        level_now = '0;
        step_now  = {1'b0, reg_step};
    endfunction

    function automatic longint clamp_mag(input bit neg, input logic [63:0] mag);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > lim) begin
            mag = lim;
            clamp_hit = 1'b1;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [DATA_W-1:0] clamp_word(input longint v);
        if (v > 64'sh7FFF_FFFF) begin
            clamp_hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            clamp_hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic deriv_word_t predict_word(input logic [DATA_W-1:0] plus_in,
                                                 input logic [DATA_W-1:0] minus_in);
        deriv_word_t r;
        longint      diff;
        longint      num;
        longint      cur;
        longint      old;
        longint      p4;
        longint      center;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] dvs;
        bit          neg;
        int          lv;
        int          lvl;
        int          sh;
        clamp_hit = 1'b0;
        lv = reg_levels;
        if (lv < 1) lv = 1;
        if (lv > MAX_LEVELS) lv = MAX_LEVELS;
        lvl = level_now;
        if (lvl >= lv) lvl = 0;

        // central difference times 1/(2h), scaled by 2^level
        diff = longint'($signed(plus_in)) - longint'($signed(minus_in));
        neg  = diff < 0;
        mag  = neg ? -diff : diff;
        prod = mag * {33'b0, reg_inv};
        sh   = FRAC_BITS - lvl;
        if (sh > 0) prod = (prod + (64'd1 << (sh - 1))) >> sh;
        cur = clamp_mag(neg, prod);

        // row update in place
        for (int j = 1; j <= lvl; j++) begin
            old            = row_mem[j-1];
            row_mem[j-1]   = cur;
            p4             = longint'(1) << (2 * j);
            num            = p4 * cur - old;
            neg            = num < 0;
            mag            = neg ? -num : num;
            dvs            = 64'(p4 - 1);
            cur            = clamp_mag(neg, (mag + dvs / 2) / dvs);
        end
        row_mem[lvl] = cur;

        r.is_final = (lvl + 1 >= lv);
        if (r.is_final) begin
            restart_sequence();
        end else begin
            level_now = LEVEL_W'(lvl + 1);
            step_now  = step_now >> 1;
        end

        center             = longint'($signed(reg_center));
        r.estimate         = cur[DATA_W-1:0];
        r.next_plus_point  = clamp_word(center + longint'(step_now));
        r.next_minus_point = clamp_word(center - longint'(step_now));
        r.saturated        = clamp_hit;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            if (error_count < 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        deriv_word_t want;
        if (!aresetn) begin
            reg_center  = '0;
            reg_step    = STEP_W'(655);
            reg_inv     = STEP_W'(3276800);
            reg_levels  = LCOUNT_W'(5);
            foreach (row_mem[k]) row_mem[k] = 0;
            restart_sequence();
            expected_q.delete();
            error_count = 0;
            pending    <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (error_count < 10)
                        $display("result word with none expected: estimate %h", m_estimate);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("estimate", want.estimate, m_estimate);
                    check_field("is_final", {31'b0, want.is_final}, {31'b0, m_is_final});
                    check_field("next_plus_point", want.next_plus_point,
                                m_next_plus_point);
                    check_field("next_minus_point", want.next_minus_point,
                                m_next_minus_point);
                    check_field("saturated", {31'b0, want.saturated},
                                {31'b0, m_saturated});
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CENTER_POINT:   reg_center = cfg_data;
                    REG_STEP_SIZE:      reg_step   = cfg_data[STEP_W-1:0];
                    REG_INV_TWICE_STEP: reg_inv    = cfg_data[STEP_W-1:0];
                    REG_LEVEL_COUNT:    reg_levels = cfg_data[LCOUNT_W-1:0];
                    default: ;
                endcase
                restart_sequence();
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_word(s_sample_plus, s_sample_minus));
            pending <= expected_q.size();
        end
    end

endmodule

[verif/tb_richardson_derivative_estimator_unit.sv]
// ----------------------------------------------------------------------------
// tb_richardson_derivative_estimator_unit
// Drives sample pairs into the estimator through a short directed run and
// then randomly configured phases, with random gaps on the input and random
// back-pressure on the result side; the result checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_richardson_derivative_estimator_unit;

    import rde_pkg::*;
    import rde_tb_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int TOTAL_WORDS = 750;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [DATA_W-1:0]    cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [DATA_W-1:0]    s_sample_plus  = '0;
    logic [DATA_W-1:0]    s_sample_minus = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [DATA_W-1:0]    m_estimate;
    logic                 m_is_final;
    logic [DATA_W-1:0]    m_next_plus_point;
    logic [DATA_W-1:0]    m_next_minus_point;
    logic                 m_saturated;

    int pending;
    int error_count;
    int words_sent = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    richardson_derivative_estimator_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_plus      (s_sample_plus),
        .s_sample_minus     (s_sample_minus),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_estimate         (m_estimate),
        .m_is_final         (m_is_final),
        .m_next_plus_point  (m_next_plus_point),
        .m_next_minus_point (m_next_minus_point),
        .m_saturated        (m_saturated)
    );

    rde_result_checker result_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_plus      (s_sample_plus),
        .s_sample_minus     (s_sample_minus),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_estimate         (m_estimate),
        .m_is_final         (m_is_final),
        .m_next_plus_point  (m_next_plus_point),
        .m_next_minus_point (m_next_minus_point),
        .m_saturated        (m_saturated),
        .pending            (pending),
        .error_count        (error_count)
    );

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [DATA_W-1:0] plus_in,
                             input logic [DATA_W-1:0] minus_in);
        calm <= (words_sent >= 300) && (words_sent < 420);
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 50);
        end
        s_valid        <= 1'b1;
        s_sample_plus  <= plus_in;
        s_sample_minus <= minus_in;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // stop sending and wait for every outstanding result word
    task automatic settle(input int tail);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] center, input logic [DATA_W-1:0] step,
                             input logic [DATA_W-1:0] inv, input logic [DATA_W-1:0] levels);
        write_reg(REG_CENTER_POINT, center);
        write_reg(REG_STEP_SIZE, step);
        write_reg(REG_INV_TWICE_STEP, inv);
        write_reg(REG_LEVEL_COUNT, levels);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config();
        logic [DATA_W-1:0] center;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] inv;
        logic [DATA_W-1:0] levels;
        if ($urandom_range(0, 3) == 0) begin
            // unused index: only restarts the sequence
            write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_REG_COUNT)),
                      $urandom());
            cfg_wr_en <= 1'b0;
        end else begin
            case ($urandom_range(0, 4))
                0:       center = 32'h7FFF_FFFF;
                1:       center = 32'h8000_0000;
                2:       center = $urandom() >> 8;
                default: center = $urandom();
            endcase
            case ($urandom_range(0, 4))
                0:       step = 32'h0000_0001;
                1:       step = 32'hFFFF_FFFF;
                default: step = $urandom() >> $urandom_range(0, 24);
            endcase
            if (step[STEP_W-1:0] == '0) step = 32'h0000_0001;
            case ($urandom_range(0, 4))
                0:       inv = 32'h0000_0001;
                1:       inv = 32'hFFFF_FFFF;
                default: inv = $urandom() >> $urandom_range(8, 24);
            endcase
            if (inv[STEP_W-1:0] == '0) inv = 32'h0000_0001;
            case ($urandom_range(0, 9))
                0:       levels = 32'd1;
                1:       levels = 32'd16;
                2:       levels = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(17, 31);
                default: levels = $urandom_range(2, 15);
            endcase
            configure(center, step, inv, levels);
        end
    endtask

    task automatic make_pair(output logic [DATA_W-1:0] plus_in,
                             output logic [DATA_W-1:0] minus_in);
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] delta;
        case ($urandom_range(0, 9))
            0: begin
                plus_in  = $urandom();
                minus_in = $urandom();
            end
            1: begin
                plus_in  = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                minus_in = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default: begin
                // nearby samples of a smooth function
                base  = $urandom();
                delta = $urandom() >> $urandom_range(12, 31);
                if ($urandom_range(0, 1) == 0) delta = -delta;
                plus_in  = base + delta;
                minus_in = base - delta;
            end
        endcase
    endtask

    initial begin
        logic [DATA_W-1:0] plus_in;
        logic [DATA_W-1:0] minus_in;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: extremes of the difference
        push_word(32'h7FFF_FFFF, 32'h8000_0000);
        push_word(32'h8000_0000, 32'h7FFF_FFFF);
        push_word(32'h0000_0000, 32'h0000_0000);
        push_word(32'h0001_0000, 32'hFFFF_0000);
        push_word(32'hFFFF_FFFF, 32'h0000_0000);
        settle(4);

        // zero level count acts as one, abscissa clamps at the top
        configure(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'd0);
        push_word(32'h0002_0000, 32'h0001_0000);
        push_word(32'h7FFF_FFFF, 32'h8000_0000);
        push_word(32'h0000_0000, 32'h0000_0001);
        settle(4);

        // level count above the maximum, step shrinks to zero, bottom clamp
        write_reg(CFG_IDX_W'(CFG_REG_COUNT + 5), 32'hFFFF_FFFF);
        configure(32'h8000_0000, 32'h0000_0001, 32'h0000_8000, 32'd31);
        repeat (17) begin
            make_pair(plus_in, minus_in);
            push_word(plus_in, minus_in);
        end

        while (words_sent < TOTAL_WORDS) begin
            settle(4);
            random_config();
            repeat ($urandom_range(20, 80)) begin
                make_pair(plus_in, minus_in);
                push_word(plus_in, minus_in);
            end
        end
        settle(60);

        if (error_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rde_pkg.sv
hw/rtl/rde_row_ram.sv
hw/rtl/rde_mul.sv
hw/rtl/richardson_derivative_estimator_unit.sv
verif/rde_tb_pkg.sv
verif/rde_result_checker.sv
verif/tb_richardson_derivative_estimator_unit.sv
